// ----- rtl/fir_conv_pkg.sv -----
// Package for the FIR convolution block: shared constants, item codes,
// controller states and the control structs passed between modules.
// No dependencies.
`default_nettype none

package fir_conv_pkg;

  // Default sizes for the top-level parameters
  localparam int MAX_TAPS_DEF    = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int RESULT_BITS     = 40;
  localparam int TAP_COUNT_BITS  = 6;
  localparam int COEF_INDEX_BITS = 5;

  // Tap count after reset
  localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET = 6'd32;

  // Width of one multiplier digit of the sample operand
  localparam int DIGIT_BITS = 4;

  // Item kinds carried in the mode field
  localparam logic MODE_COEF   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_MAC,
    S_OUT
  } fir_state_t;

  // Controls for the coefficient store and sample history
  typedef struct packed {
    logic coef_we;
    logic push;
    logic clear;
  } mem_ctrl_t;

  // Controls for the digit-serial multiply-accumulate unit
  typedef struct packed {
    logic load;
    logic first;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/fir_conv_if.sv -----
// Channel interfaces for the FIR convolution block: the item channel
// (coefficients and samples) and the result channel. Uses fir_conv_pkg.
`default_nettype none

interface fir_conv_in_if
  import fir_conv_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic        [COEF_INDEX_BITS-1:0] coef_index;
  logic signed [SAMPLE_BITS-1:0]     coef_value;
  logic signed [SAMPLE_BITS-1:0]     sample;
  logic                              last_sample;

  modport source (
    output valid, mode, coef_index, coef_value, sample, last_sample,
    input  ready
  );
  modport sink (
    input  valid, mode, coef_index, coef_value, sample, last_sample,
    output ready
  );
endinterface

interface fir_conv_out_if
  import fir_conv_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic signed [RESULT_BITS-1:0] result;
  logic                          last;

  modport source (
    output valid, result, last,
    input  ready
  );
  modport sink (
    input  valid, result, last,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/fir_conv_mem.sv -----
// Coefficient store (with per-entry valid bits) and sample history ring
// (with a fill count) for the FIR convolution block. Uses fir_conv_pkg.
`default_nettype none

module fir_conv_mem
  import fir_conv_pkg::*;
#(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IDXW = $clog2(MAX_TAPS),
  localparam int TAPW = $clog2(MAX_TAPS + 1)
) (
  input  wire                          clk,
  input  wire                          rst,
  input  mem_ctrl_t                    ctrl,
  input  wire        [IDXW-1:0]        coef_waddr,
  input  wire signed [SAMPLE_BITS-1:0] coef_wdata,
  input  wire signed [SAMPLE_BITS-1:0] push_data,
  input  wire        [IDXW-1:0]        tap_idx,
  output logic signed [SAMPLE_BITS-1:0] coef_rd,
  output logic signed [SAMPLE_BITS-1:0] samp_rd
);

  localparam int HDEPTH = 2 ** IDXW;

  logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic        [MAX_TAPS-1:0]    coef_vld;
  logic signed [SAMPLE_BITS-1:0] coef_q;
  logic                          coef_vld_q;

  logic signed [SAMPLE_BITS-1:0] hist_mem [HDEPTH];
  logic        [IDXW-1:0]        wp;
  logic        [TAPW-1:0]        fill;
  logic        [IDXW-1:0]        hist_raddr;
  logic signed [SAMPLE_BITS-1:0] samp_q;
  logic                          samp_vld_q;

  // Coefficient memory: write on request, registered read
  always_ff @(posedge clk) begin
    if (ctrl.coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    coef_q <= coef_mem[tap_idx];
  end

  // Valid bits: an unwritten coefficient reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld   <= '0;
      coef_vld_q <= 1'b0;
    end else begin
      if (ctrl.coef_we) begin
        coef_vld[coef_waddr] <= 1'b1;
      end
      coef_vld_q <= coef_vld[tap_idx];
    end
  end

  assign coef_rd = coef_vld_q ? coef_q : '0;

  // Age of the tap counts back from the newest entry
  assign hist_raddr = wp - IDXW'(1) - tap_idx;

  // History memory: push at the write pointer, registered read
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      hist_mem[wp] <= push_data;
    end
    samp_q <= hist_mem[hist_raddr];
  end

  // Write pointer and fill count; clear empties the history
  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      fill       <= '0;
      samp_vld_q <= 1'b0;
    end else begin
      if (ctrl.push) begin
        wp <= wp + IDXW'(1);
      end
      if (ctrl.clear) begin
        fill <= '0;
      end else if (ctrl.push && (fill != TAPW'(MAX_TAPS))) begin
        fill <= fill + TAPW'(1);
      end
      samp_vld_q <= (TAPW'(tap_idx) < fill);
    end
  end

  assign samp_rd = samp_vld_q ? samp_q : '0;

endmodule

`default_nettype wire

// ----- rtl/fir_conv_mac.sv -----
// Digit-serial multiply-accumulate unit: multiplies a coefficient by a
// sample one 4-bit digit per cycle into a 40-bit accumulator. Uses fir_conv_pkg.
`default_nettype none

module fir_conv_mac
  import fir_conv_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  mac_ctrl_t                    ctrl,
  input  wire signed [SAMPLE_BITS-1:0] coef,
  input  wire signed [SAMPLE_BITS-1:0] sample,
  output logic                         digit_last,
  output logic       [RESULT_BITS-1:0] acc
);

  localparam int ND  = (SAMPLE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int OPW = ND * DIGIT_BITS;
  localparam int CW  = $clog2(ND);

  logic signed [SAMPLE_BITS-1:0]          coef_r;
  logic        [OPW-1:0]                  opnd;
  logic        [CW-1:0]                   dcnt;
  logic                                   busy;
  logic        [DIGIT_BITS-1:0]           dig;
  logic signed [DIGIT_BITS:0]             dig_s;
  logic signed [SAMPLE_BITS+DIGIT_BITS:0] pp;
  logic        [RESULT_BITS-1:0]          pp_sh;

  // Current digit; the top digit carries the sample's sign
  assign dig        = opnd[DIGIT_BITS-1:0];
  assign digit_last = busy && (dcnt == CW'(ND - 1));
  assign dig_s      = (dcnt == CW'(ND - 1)) ? $signed({dig[DIGIT_BITS-1], dig})
                                            : $signed({1'b0, dig});
  assign pp         = coef_r * dig_s;
  assign pp_sh      = RESULT_BITS'(pp) << (DIGIT_BITS * dcnt);

  // Sequence control: run one digit per cycle after a load
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      dcnt <= '0;
    end else if (ctrl.load) begin
      busy <= 1'b1;
      dcnt <= '0;
    end else if (busy) begin
      dcnt <= dcnt + CW'(1);
      if (digit_last) begin
        busy <= 1'b0;
      end
    end
  end

  // Operand shift register and accumulator
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      coef_r <= coef;
      opnd   <= OPW'(sample);
      if (ctrl.first) begin
        acc <= '0;
      end
    end else if (busy) begin
      opnd <= opnd >> DIGIT_BITS;
      acc  <= acc + pp_sh;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fir_convolution_top.sv -----
// FIR convolution top level: one 16x4 multiply-accumulate per cycle in the digit phase,
// taps taken in turn, each through memory read, operand load and digits.
// A sample is accepted only in the idle state: the next one waits until the last one's
// result and any tail results are loaded into the output register, longer while the
// result channel stalls. A coefficient write is accepted in the idle state.
// Reset clears the history, marks all coefficients as zero and sets 32 taps.
`default_nettype none

module fir_convolution_top
  import fir_conv_pkg::*;
#(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      cfg_wr_en,
  input  wire [TAP_COUNT_BITS-1:0] cfg_wr_data,
  fir_conv_in_if.sink              item_ch,
  fir_conv_out_if.source           result_ch
);

  localparam int IDXW = $clog2(MAX_TAPS);
  localparam int TAPW = $clog2(MAX_TAPS + 1);

  fir_state_t                    state;
  fir_state_t                    state_next;
  logic [TAP_COUNT_BITS-1:0]     tap_count;
  logic [TAPW-1:0]               taps_use;
  logic [TAPW-1:0]               taps_r;
  logic [TAPW-1:0]               tail_left;
  logic                          fin_r;
  logic [IDXW-1:0]               k;
  logic                          k_last;
  logic                          accept;
  logic                          out_load;
  logic                          out_valid;
  logic [RESULT_BITS-1:0]        out_result;
  logic                          out_last;
  mem_ctrl_t                     mem_ctrl;
  mac_ctrl_t                     mac_ctrl;
  logic signed [SAMPLE_BITS-1:0] push_data;
  logic signed [SAMPLE_BITS-1:0] coef_rd;
  logic signed [SAMPLE_BITS-1:0] samp_rd;
  logic                          digit_last;
  logic [RESULT_BITS-1:0]        acc;

  // Tap count register
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RESET;
    end else if (cfg_wr_en) begin
      tap_count <= cfg_wr_data;
    end
  end

  // Clamp the tap count into 1..MAX_TAPS
  always_comb begin
    if (tap_count == '0) begin
      taps_use = TAPW'(1);
    end else if (int'(tap_count) > MAX_TAPS) begin
      taps_use = TAPW'(MAX_TAPS);
    end else begin
      taps_use = TAPW'(tap_count);
    end
  end

  assign accept   = item_ch.valid && (state == S_IDLE);
  assign k_last   = (TAPW'(k) + TAPW'(1)) == taps_r;
  assign out_load = (state == S_OUT) && (!out_valid || result_ch.ready);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (item_ch.mode == MODE_SAMPLE)) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_LOAD;
      S_LOAD: state_next = S_MAC;
      S_MAC: begin
        if (digit_last) begin
          state_next = k_last ? S_OUT : S_READ;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_next = (tail_left != '0) ? S_READ : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    item_ch.ready    = (state == S_IDLE);
    mem_ctrl.coef_we = accept && (item_ch.mode == MODE_COEF) &&
                       (int'(item_ch.coef_index) < MAX_TAPS);
    mem_ctrl.push    = 1'b0;
    mem_ctrl.clear   = 1'b0;
    push_data        = '0;
    mac_ctrl.load    = 1'b0;
    mac_ctrl.first   = 1'b0;
    case (state)
      S_IDLE: begin
        mem_ctrl.push = accept && (item_ch.mode == MODE_SAMPLE);
        push_data     = item_ch.sample;
      end
      S_LOAD: begin
        mac_ctrl.load  = 1'b1;
        mac_ctrl.first = (k == '0);
      end
      S_OUT: begin
        // Shift a zero in for the next tail result, or drop the history
        mem_ctrl.push  = out_load && (tail_left != '0);
        mem_ctrl.clear = out_load && (tail_left == '0) && fin_r;
      end
      default: begin
      end
    endcase
  end

  // State register and run counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      taps_r    <= TAPW'(1);
      tail_left <= '0;
      fin_r     <= 1'b0;
      k         <= '0;
    end else begin
      state <= state_next;
      if (accept && (item_ch.mode == MODE_SAMPLE)) begin
        taps_r    <= taps_use;
        fin_r     <= item_ch.last_sample;
        tail_left <= item_ch.last_sample ? (taps_use - TAPW'(1)) : '0;
        k         <= '0;
      end else if ((state == S_MAC) && digit_last && !k_last) begin
        k <= k + IDXW'(1);
      end else if (out_load && (tail_left != '0)) begin
        tail_left <= tail_left - TAPW'(1);
        k         <= '0;
      end
    end
  end

  // Output register: hold a result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result <= acc;
      out_last   <= fin_r && (tail_left == '0);
    end
  end

  assign result_ch.valid  = out_valid;
  assign result_ch.result = out_result;
  assign result_ch.last   = out_last;

  fir_conv_mem #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mem (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (mem_ctrl),
    .coef_waddr (IDXW'(item_ch.coef_index)),
    .coef_wdata (item_ch.coef_value),
    .push_data  (push_data),
    .tap_idx    (k),
    .coef_rd    (coef_rd),
    .samp_rd    (samp_rd)
  );

  fir_conv_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (mac_ctrl),
    .coef       (coef_rd),
    .sample     (samp_rd),
    .digit_last (digit_last),
    .acc        (acc)
  );

endmodule

`default_nettype wire

// ----- sim/tb_fir_convolution_top.sv -----
// Testbench for fir_convolution_top: drives coefficient and sample items, predicts
// every convolution output including tail flushes, and checks them in order.
// Depends on fir_conv_pkg, fir_conv_in_if/fir_conv_out_if and the top level RTL.
`default_nettype none

module tb_fir_convolution_top
  import fir_conv_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB           = SAMPLE_BITS_DEF;
  localparam int TAPS         = MAX_TAPS_DEF;
  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 9;
  // Longest single output: a pass over every tap at full length plus the output register
  localparam int DRAIN_CYCLES = 6 * TAPS + 1 + 32;
  localparam int HOLD_CYCLES  = 2500;
  // Every item flushing 32 outputs, each waiting out a long receiver stall, times three
  localparam longint CYCLE_LIMIT = 8_000_000;
  localparam int MAX_REPORTS  = 10;

  localparam logic signed [SB-1:0] Q15_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] Q15_MAX = {1'b0, {(SB-1){1'b1}}};

  typedef struct packed {
    logic signed [RESULT_BITS-1:0] result;
    logic                          last;
  } conv_out_t;

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      cfg_wr_en   = 1'b0;
  logic [TAP_COUNT_BITS-1:0] cfg_wr_data = '0;

  fir_conv_in_if #(.SAMPLE_BITS(SB)) item_ch ();
  fir_conv_out_if                    result_ch ();

  fir_convolution_top #(
    .MAX_TAPS   (TAPS),
    .SAMPLE_BITS(SB)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .item_ch    (item_ch),
    .result_ch  (result_ch)
  );

  // Filter state as seen from the ports
  logic signed [SB-1:0]      coef_mem [TAPS];
  logic signed [SB-1:0]      hist_mem [TAPS-1];
  logic [TAP_COUNT_BITS-1:0] tap_reg;
  conv_out_t                 pending_outputs [$];

  int     errors        = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     stall_ask     = 0;
  int     stall_seen    = 0;
  int     stall_left    = 0;
  longint cycle_count   = 0;

  always #(HALF_PERIOD) clk = ~clk;

  // Clamp the programmed tap count to 1..TAPS
  function automatic int taps_active();
    int t;
    t = tap_reg;
    if (t < 1) t = 1;
    if (t > TAPS) t = TAPS;
    return t;
  endfunction

  // Sum coefficient times delayed sample, then shift the new sample into the history
  function automatic logic signed [RESULT_BITS-1:0] filter_step(
    input logic signed [SB-1:0] x,
    input int                   taps
  );
    logic signed [RESULT_BITS-1:0] acc;
    logic signed [2*SB-1:0]        prod;
    int                            k;
    acc = '0;
    for (k = 0; k < taps; k++) begin
      if (k == 0) prod = coef_mem[0] * x;
      else prod = coef_mem[k] * hist_mem[k-1];
      acc = acc + prod;
    end
    for (k = TAPS - 2; k > 0; k--) hist_mem[k] = hist_mem[k-1];
    hist_mem[0] = x;
    return acc;
  endfunction

  // Update the filter state for one accepted item and queue its outputs
  task automatic convolve_item(
    input logic                       mode,
    input logic [COEF_INDEX_BITS-1:0] idx,
    input logic signed [SB-1:0]       cval,
    input logic signed [SB-1:0]       smp,
    input logic                       lst
  );
    int        taps;
    int        k;
    conv_out_t o;
    if (mode == MODE_COEF) begin
      coef_mem[idx] = cval;
    end else begin
      taps     = taps_active();
      o.result = filter_step(smp, taps);
      o.last   = lst && (taps == 1);
      pending_outputs.push_back(o);
      // Flush the tail with zeros and start the next run from silence
      if (lst) begin
        for (k = 1; k < taps; k++) begin
          o.result = filter_step('0, taps);
          o.last   = (k == taps - 1);
          pending_outputs.push_back(o);
        end
        foreach (hist_mem[i]) hist_mem[i] = '0;
      end
    end
  endtask

  function automatic logic signed [SB-1:0] pick_q15();
    case ($urandom_range(0, 9))
      0:       return Q15_MIN;
      1:       return Q15_MAX;
      default: return SB'($urandom);
    endcase
  endfunction

  // Offer one item after an optional idle gap; predict once the transaction completes
  task automatic send_item(
    input logic                       mode,
    input logic [COEF_INDEX_BITS-1:0] idx,
    input logic signed [SB-1:0]       cval,
    input logic signed [SB-1:0]       smp,
    input logic                       lst
  );
    if ($urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    item_ch.valid       <= 1'b1;
    item_ch.mode        <= mode;
    item_ch.coef_index  <= idx;
    item_ch.coef_value  <= cval;
    item_ch.sample      <= smp;
    item_ch.last_sample <= lst;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    convolve_item(mode, idx, cval, smp, lst);
  endtask

  // Unused fields carry random junk
  task automatic write_coef(input int idx, input int cval);
    send_item(MODE_COEF, COEF_INDEX_BITS'(idx), SB'(cval), SB'($urandom), 1'($urandom));
  endtask

  task automatic push_sample(input logic signed [SB-1:0] smp, input logic lst);
    send_item(MODE_SAMPLE, COEF_INDEX_BITS'($urandom), SB'($urandom), smp, lst);
  endtask

  // Drop valid, wait for every queued output, then let a full-length pass finish
  task automatic drain_pipeline();
    item_ch.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the tap count register; only called with the block idle
  task automatic set_tap_count(input int value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= TAP_COUNT_BITS'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tap_reg      = TAP_COUNT_BITS'(value);
  endtask

  // Reset state: zero coefficients, 32 taps, full zero tail
  task automatic test_reset_defaults();
    push_sample(Q15_MIN, 1'b1);
  endtask

  // Largest products of both signs through a short response
  task automatic test_extreme_products();
    drain_pipeline();
    set_tap_count(4);
    write_coef(0, Q15_MAX);
    write_coef(1, Q15_MIN);
    write_coef(2, Q15_MIN);
    write_coef(3, Q15_MAX);
    // Outside the taps in use, must not show up
    write_coef(TAPS - 1, -1);
    push_sample(Q15_MIN, 1'b0);
    push_sample(Q15_MAX, 1'b0);
    push_sample(Q15_MIN, 1'b0);
    push_sample('0, 1'b1);
  endtask

  // One tap: the sample's own output is the final one
  task automatic test_single_tap();
    drain_pipeline();
    set_tap_count(1);
    push_sample(Q15_MAX, 1'b1);
    push_sample(Q15_MIN, 1'b0);
  endtask

  // Zero acts as one tap, values past the store saturate to full length
  task automatic test_tap_count_limits();
    drain_pipeline();
    set_tap_count(0);
    push_sample(Q15_MIN, 1'b1);
    drain_pipeline();
    set_tap_count('1);
    push_sample(Q15_MAX, 1'b1);
  endtask

  // Shrink and regrow the tap count inside one run; old history must survive
  task automatic test_tap_change_mid_run();
    int n;
    drain_pipeline();
    set_tap_count(TAPS);
    for (n = 0; n < 3; n++) push_sample(pick_q15(), 1'b0);
    drain_pipeline();
    set_tap_count(3);
    for (n = 0; n < 2; n++) push_sample(pick_q15(), 1'b0);
    drain_pipeline();
    set_tap_count(TAPS);
    push_sample(pick_q15(), 1'b1);
  endtask

  // Runs of a loaded response followed by a stream of samples and stray writes
  task automatic test_random_traffic();
    int run;
    int n;
    int k;
    int taps;
    for (run = 0; run < 3; run++) begin
      drain_pipeline();
      case ($urandom_range(0, 9))
        0:       set_tap_count(TAPS);
        1:       set_tap_count($urandom_range(0, 63));
        2, 3:    set_tap_count($urandom_range(9, 31));
        default: set_tap_count($urandom_range(1, 8));
      endcase
      taps = taps_active();
      for (k = 0; k < taps; k++) write_coef(k, pick_q15());
      for (n = 0; n < 12; n++) begin
        if ($urandom_range(0, 99) < 15) write_coef($urandom_range(0, TAPS - 1), pick_q15());
        else push_sample(pick_q15(), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // Hold the receiver off while samples keep coming, so the input stalls
  task automatic test_backpressure_fill();
    int n;
    drain_pipeline();
    set_tap_count(2);
    write_coef(0, pick_q15());
    write_coef(1, pick_q15());
    stall_ask++;
    for (n = 0; n < 40; n++) push_sample(pick_q15(), (n % 10) == 9);
  endtask

  // Check each output transaction against the oldest prediction; pick ready
  always @(posedge clk) begin
    conv_out_t exp_out;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_outputs.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("unexpected output: result %0d last %0b",
                     result_ch.result, result_ch.last);
          errors++;
        end else begin
          exp_out = pending_outputs.pop_front();
          if (result_ch.result !== exp_out.result || result_ch.last !== exp_out.last) begin
            if (errors < MAX_REPORTS)
              $display("output mismatch: expected result %0d last %0b, got result %0d last %0b",
                       exp_out.result, exp_out.last, result_ch.result, result_ch.last);
            errors++;
          end
        end
      end
      // Start a long hold when asked, otherwise stall at random
      if (stall_ask != stall_seen) begin
        stall_seen = stall_ask;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Abort a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("fir_convolution_top test failed");
    $finish;
  end

  initial begin
    item_ch.valid       = 1'b0;
    item_ch.mode        = MODE_COEF;
    item_ch.coef_index  = '0;
    item_ch.coef_value  = '0;
    item_ch.sample      = '0;
    item_ch.last_sample = 1'b0;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    foreach (hist_mem[i]) hist_mem[i] = '0;
    tap_reg = TAP_COUNT_RESET;

    send_idle_pct = 31;
    recv_idle_pct = 68;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_extreme_products();
    test_single_tap();
    test_tap_count_limits();
    test_tap_change_mid_run();
    test_random_traffic();

    send_idle_pct = 68;
    recv_idle_pct = 31;
    test_random_traffic();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic();
    test_backpressure_fill();

    drain_pipeline();
    if (errors == 0) $display("fir_convolution_top test passed");
    else $display("fir_convolution_top test failed");
    $finish;
  end

endmodule

`default_nettype wire
